// ===== rtl/core/http_request_line_checker_defines.svh =====
// ----------------------------------------------------------------------------
// http request line checker assertion macros
// shared concurrent check forms, removed when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_CHECKER_DEFINES_SVH
`define HTTP_REQUEST_LINE_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HRLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define HRLC_ASSERT_IMP(lbl, ante, cons, msg)
`define HRLC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/hrlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlc_pkg
// types, character codes and verdict codes of the request line checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrlc_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;

  localparam int unsigned METHOD_MAX_LEN = 6;
  localparam int unsigned VERSION_LEN    = 8;

  // byte 0 in the low bits
  localparam logic [7:0] VERSION_TEXT [VERSION_LEN] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31
  };

  typedef enum logic [1:0] {
    MC_GET    = 2'd0,
    MC_POST   = 2'd1,
    MC_DELETE = 2'd2,
    MC_HEAD   = 2'd3
  } method_t;

  localparam logic [47:0] METHOD_NAME [4] = '{
    48'h0000_0054_4547,
    48'h0000_5453_4F50,
    48'h4554_454C_4544,
    48'h0000_4441_4548
  };
  localparam logic [2:0] METHOD_LEN [4] = '{3'd3, 3'd4, 3'd6, 3'd4};

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NO_CRLF    = 4'd1,
    ST_EMPTY      = 4'd2,
    ST_EDGE_SPACE = 4'd3,
    ST_TAB        = 4'd4,
    ST_DBL_SPACE  = 4'd5,
    ST_FEW_TOKENS = 4'd6,
    ST_MANY_TOKENS= 4'd7,
    ST_LOWER_METH = 4'd8,
    ST_UNKNOWN_METH = 4'd9,
    ST_BAD_URI    = 4'd10,
    ST_BAD_VERSION = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  // fault bits
  localparam int unsigned FLT_LEAD = 0;
  localparam int unsigned FLT_TAB  = 1;
  localparam int unsigned FLT_DBL  = 2;

  typedef struct packed {
    logic [7:0]  prev_char;
    logic [15:0] position;
    logic [2:0]  token_count;
    logic        inside_token;
    logic [47:0] method_chars;
    logic [2:0]  method_length;
    logic        method_upper;
    logic        uri_slash;
    logic [15:0] uri_offset;
    logic [15:0] uri_length;
    logic [3:0]  ver_count;
    logic        ver_bad;
    logic [2:0]  faults;
  } line_t;

  localparam line_t LINE_CLEAR = '{
    prev_char:     8'd0,
    position:      16'd0,
    token_count:   3'd0,
    inside_token:  1'b0,
    method_chars:  48'd0,
    method_length: 3'd0,
    method_upper:  1'b1,
    uri_slash:     1'b0,
    uri_offset:    16'd0,
    uri_length:    16'd0,
    ver_count:     4'd0,
    ver_bad:       1'b0,
    faults:        3'd0
  };

  typedef struct packed {
    logic [15:0] line_length;
    logic [15:0] uri_length;
    logic [15:0] uri_offset;
    method_t     method_code;
    status_t     status;
  } result_t;

endpackage

// ===== rtl/core/hrlc_judge.sv =====
// ----------------------------------------------------------------------------
// hrlc_judge
// verdict for a line closed by cr lf, first fault in precedence order wins
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrlc_judge (
  input  hrlc_pkg::line_t   line_i,
  output hrlc_pkg::result_t verdict_o
);
  import hrlc_pkg::*;

  logic    meth_hit;
  method_t meth_code;
  status_t status;

  always_comb begin
    meth_hit  = 1'b0;
    meth_code = MC_GET;
    for (int k = 3; k >= 0; k--) begin
      if (line_i.method_length == METHOD_LEN[k] && line_i.method_chars == METHOD_NAME[k]) begin
        meth_hit  = 1'b1;
        meth_code = method_t'(k[1:0]);
      end
    end
  end

  always_comb begin
    priority if (line_i.position == 16'd0) begin
      status = ST_EMPTY;
    end else if (line_i.faults[FLT_LEAD] || line_i.prev_char == CH_SP) begin
      status = ST_EDGE_SPACE;
    end else if (line_i.faults[FLT_TAB]) begin
      status = ST_TAB;
    end else if (line_i.faults[FLT_DBL]) begin
      status = ST_DBL_SPACE;
    end else if (line_i.token_count < 3'd3) begin
      status = ST_FEW_TOKENS;
    end else if (line_i.token_count > 3'd3) begin
      status = ST_MANY_TOKENS;
    end else if (!line_i.method_upper) begin
      status = ST_LOWER_METH;
    end else if (!meth_hit) begin
      status = ST_UNKNOWN_METH;
    end else if (!line_i.uri_slash) begin
      status = ST_BAD_URI;
    end else if (line_i.ver_bad || line_i.ver_count != 4'(VERSION_LEN)) begin
      status = ST_BAD_VERSION;
    end else begin
      status = ST_OK;
    end
  end

  assign verdict_o = '{
    line_length: line_i.position,
    uri_length:  line_i.uri_length,
    uri_offset:  line_i.uri_offset,
    method_code: (status == ST_OK) ? meth_code : MC_GET,
    status:      status
  };

endmodule

// ===== rtl/core/hrlc_scan.sv =====
// ----------------------------------------------------------------------------
// hrlc_scan
// per-byte line state, cr lf detection and result generation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrlc_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              first_i,
  input  logic              eod_i,
  output logic              res_valid_o,
  output hrlc_pkg::result_t res_o
);
  import hrlc_pkg::*;

  `include "http_request_line_checker_defines.svh"

  phase_t  phase_r, phase_nxt;
  logic    cr_pend_r, cr_pend_nxt;
  line_t   line_r, line_nxt;
  result_t verdict;

  phase_t ph_cur;
  line_t  line_cur, line_a, line_b, line_d;
  logic   cp_cur, lf_close, is_cr;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic line_t feed(input line_t s, input logic [7:0] c);
    line_t r;
    logic  sep;
    r   = s;
    sep = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
    if (s.position == 16'd0 && c == CH_SP) r.faults[FLT_LEAD] = 1'b1;
    if (c == CH_TAB) r.faults[FLT_TAB] = 1'b1;
    if (c == CH_SP && s.position != 16'd0 && s.prev_char == CH_SP) r.faults[FLT_DBL] = 1'b1;
    if (sep) begin
      r.inside_token = 1'b0;
    end else begin
      if (!s.inside_token) begin
        r.inside_token = 1'b1;
        if (s.token_count < 3'd4) r.token_count = s.token_count + 3'd1;
        if (r.token_count == 3'd2) begin
          r.uri_offset = s.position;
          r.uri_length = 16'd0;
          r.uri_slash  = (c == CH_SLASH);
        end
      end
      if (r.token_count == 3'd1) begin
        for (int i = 0; i < METHOD_MAX_LEN; i++) begin
          if (s.method_length == 3'(i)) r.method_chars[8*i +: 8] = c;
        end
        if (s.method_length < 3'd7) r.method_length = s.method_length + 3'd1;
        if (c < CH_UA || c > CH_UZ) r.method_upper = 1'b0;
      end else if (r.token_count == 3'd2) begin
        r.uri_length = sat_inc(r.uri_length);
      end else if (r.token_count == 3'd3) begin
        if (!s.ver_bad) begin
          if (s.ver_count < 4'(VERSION_LEN) && c == VERSION_TEXT[s.ver_count[2:0]]) begin
            r.ver_count = s.ver_count + 4'd1;
          end else begin
            r.ver_bad = 1'b1;
          end
        end
      end
    end
    r.prev_char = c;
    r.position  = sat_inc(s.position);
    return r;
  endfunction

  hrlc_judge u_judge (
    .line_i    (line_r),
    .verdict_o (verdict)
  );

  // restart and byte chain
  always_comb begin
    ph_cur   = first_i ? PH_SCAN : phase_r;
    line_cur = first_i ? LINE_CLEAR : line_r;
    cp_cur   = first_i ? 1'b0 : cr_pend_r;
    is_cr    = (byte_i == CH_CR);
    lf_close = cp_cur && byte_i == CH_LF;
    line_a   = cp_cur ? feed(line_cur, CH_CR) : line_cur;
    line_b   = is_cr ? line_a : feed(line_a, byte_i);
    line_d   = (eod_i && is_cr) ? feed(line_b, CH_CR) : line_b;
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (step_i) begin
      unique case (ph_cur)
        PH_SCAN: phase_nxt = (lf_close || eod_i) ? PH_DONE : PH_SCAN;
        PH_IDLE: phase_nxt = PH_IDLE;
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // line state and result
  always_comb begin
    line_nxt    = line_r;
    cr_pend_nxt = cr_pend_r;
    res_valid_o = 1'b0;
    res_o       = verdict;
    if (step_i) begin
      line_nxt    = line_cur;
      cr_pend_nxt = cp_cur;
      if (ph_cur == PH_SCAN) begin
        if (lf_close) begin
          cr_pend_nxt = 1'b0;
          res_valid_o = 1'b1;
          res_o       = verdict;
        end else begin
          line_nxt    = line_d;
          cr_pend_nxt = is_cr && !eod_i;
          res_valid_o = eod_i;
          res_o = '{
            line_length: line_d.position,
            uri_length:  line_d.uri_length,
            uri_offset:  line_d.uri_offset,
            method_code: MC_GET,
            status:      ST_NO_CRLF
          };
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cr_pend_r <= 1'b0;
      line_r    <= LINE_CLEAR;
    end else begin
      phase_r   <= phase_nxt;
      cr_pend_r <= cr_pend_nxt;
      line_r    <= line_nxt;
    end
  end

  `HRLC_ASSERT_IMP(a_res_from_scan, res_valid_o, phase_r == PH_SCAN || first_i,
    "result outside a scanned line")
  `HRLC_ASSERT_NXT(a_done_after_res, res_valid_o, phase_r == PH_DONE,
    "line not closed after its verdict")
  `HRLC_ASSERT_IMP(a_uri_needs_token, line_r.uri_length != 16'd0,
    line_r.token_count >= 3'd2, "uri length without a second token")

endmodule

// ===== rtl/core/http_request_line_checker.sv =====
// ----------------------------------------------------------------------------
// http_request_line_checker
// checks the request line of an http/1.1 message, one verdict per line
// ----------------------------------------------------------------------------
// Takes one message byte per cycle on the in_ stream unless a verdict stalls,
// and gives one verdict per request line on the out_ stream at the first cr lf
// or at tlast. Each byte passes through an input register, one short pass of
// scan logic and a result register, so a byte can be accepted in every cycle
// unless a verdict stalls; the verdict is registered as the closing byte
// leaves the input register. in_tready drops only while the input register
// holds a byte and a finished verdict is stalled by out_tready. Bytes outside
// a line are dropped until in_tuser marks the first byte of the next message.
`timescale 1ns / 1ps

module http_request_line_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // byte_in
  input  logic        in_tuser,   // first_byte
  input  logic        in_tlast,   // end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[3:0] method_code[5:4] uri_offset[21:6] uri_length[37:22]
  // line_length[53:38] zero[55:54]
  output logic [55:0] out_tdata
);
  import hrlc_pkg::*;

  `include "http_request_line_checker_defines.svh"

  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic               in_first_r;
  logic               in_last_r;
  logic               out_valid_r;
  result_t            out_res_r;
  logic               step;
  logic               res_valid;
  result_t            res;

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
  end

  hrlc_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .byte_i      (in_byte_r),
    .first_i     (in_first_r),
    .eod_i       (in_last_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

  `HRLC_ASSERT_IMP(a_stall_reason, !in_tready, in_valid_r && out_valid_r && !out_tready,
    "input stalled without a stalled verdict")
  `HRLC_ASSERT_IMP(a_fall_on_take, $fell(out_valid_r), $past(out_tready),
    "verdict dropped without being taken")
  `HRLC_ASSERT_NXT(a_hold_unstepped, in_valid_r && !step, in_valid_r,
    "buffered byte lost")

endmodule

// ===== dv/http_request_line_checker_tb.sv =====
// ----------------------------------------------------------------------------
// http_request_line_checker_tb
// self-checking bench for the request line checker
// ----------------------------------------------------------------------------
// Streams request messages into the checker one word at a time: a few short
// directed messages, then random request lines. Four in ten random lines are
// well formed with random content; the others carry one flaw each or are plain
// noise; any line may be cut short. A scoreboard class tracks the line state
// of the checker, works out the verdict expected for every line and compares
// each verdict read from the output stream field by field. The sender idles
// in bursts and the receiver stalls on a pattern that changes through the run.
`timescale 1ns / 1ps

module http_request_line_checker_tb;
  import hrlc_pkg::*;

  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int unsigned TOTAL_WORDS = 1650;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef enum int unsigned {
    F_NONE, F_LOWER, F_UNKNOWN, F_BAD_URI, F_BAD_VER, F_TAB, F_DBL, F_LEAD,
    F_TRAIL, F_FEW, F_MANY, F_ALT_SEP, F_NO_CRLF, F_EMPTY, F_NOISE
  } flaw_t;

  class line_scoreboard;
    phase_t      phase;
    bit          cr_pending;
    logic [7:0]  prev_char;
    logic [15:0] position;
    int unsigned token_count;
    bit          in_token;
    logic [47:0] method_chars;
    int unsigned method_len;
    bit          method_upper;
    bit          uri_slash;
    logic [15:0] uri_offset;
    logic [15:0] uri_length;
    int unsigned ver_count;
    bit          ver_bad;
    bit          lead_space;
    bit          saw_tab;
    bit          dbl_space;
    result_t     pending[$];
    int          errors;

    function new();
      phase = PH_IDLE;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      cr_pending = 0;
      prev_char = 8'd0;
      position = 16'd0;
      token_count = 0;
      in_token = 0;
      method_chars = 48'd0;
      method_len = 0;
      method_upper = 1;
      uri_slash = 0;
      uri_offset = 16'd0;
      uri_length = 16'd0;
      ver_count = 0;
      ver_bad = 0;
      lead_space = 0;
      saw_tab = 0;
      dbl_space = 0;
    endfunction

    function void scan_char(logic [7:0] c);
      bit sep;
      sep = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
      if (position == 16'd0 && c == CH_SP) lead_space = 1;
      if (c == CH_TAB) saw_tab = 1;
      if (c == CH_SP && position != 16'd0 && prev_char == CH_SP) dbl_space = 1;
      if (sep) begin
        in_token = 0;
      end else begin
        if (!in_token) begin
          in_token = 1;
          if (token_count < 4) token_count++;
          if (token_count == 2) begin
            uri_offset = position;
            uri_length = 16'd0;
            uri_slash = (c == CH_SLASH);
          end
        end
        if (token_count == 1) begin
          if (method_len < METHOD_MAX_LEN) method_chars[8*method_len +: 8] = c;
          if (method_len < 7) method_len++;
          if (c < CH_UA || c > CH_UZ) method_upper = 0;
        end else if (token_count == 2) begin
          if (uri_length != 16'hFFFF) uri_length++;
        end else if (token_count == 3) begin
          if (!ver_bad) begin
            if (ver_count < VERSION_LEN && c == VERSION_TEXT[ver_count]) ver_count++;
            else ver_bad = 1;
          end
        end
      end
      prev_char = c;
      if (position != 16'hFFFF) position++;
    endfunction

    function void push_verdict(status_t st, method_t mc);
      result_t r;
      r.status = st;
      r.method_code = mc;
      r.uri_offset = uri_offset;
      r.uri_length = uri_length;
      r.line_length = position;
      pending.push_back(r);
    endfunction

    function void judge_line();
      int code;
      status_t st;
      code = -1;
      for (int k = 0; k < 4; k++) begin
        if (code < 0 && method_len == METHOD_LEN[k] && method_chars == METHOD_NAME[k])
          code = k;
      end
      if (position == 16'd0) st = ST_EMPTY;
      else if (lead_space || prev_char == CH_SP) st = ST_EDGE_SPACE;
      else if (saw_tab) st = ST_TAB;
      else if (dbl_space) st = ST_DBL_SPACE;
      else if (token_count < 3) st = ST_FEW_TOKENS;
      else if (token_count > 3) st = ST_MANY_TOKENS;
      else if (!method_upper) st = ST_LOWER_METH;
      else if (code < 0) st = ST_UNKNOWN_METH;
      else if (!uri_slash) st = ST_BAD_URI;
      else if (ver_bad || ver_count != VERSION_LEN) st = ST_BAD_VERSION;
      else st = ST_OK;
      push_verdict(st, (st == ST_OK) ? method_t'(code) : MC_GET);
    endfunction

    // returns 1 when the word belongs to a line being scanned
    function bit note_byte(logic [7:0] c, bit first, bit last);
      if (first) begin
        clear_line();
        phase = PH_SCAN;
      end
      if (phase != PH_SCAN) return 0;
      if (cr_pending) begin
        cr_pending = 0;
        if (c == CH_LF) begin
          judge_line();
          phase = PH_DONE;
          return 1;
        end
        scan_char(CH_CR);
      end
      if (c == CH_CR) cr_pending = 1;
      else scan_char(c);
      if (last) begin
        if (cr_pending) begin
          cr_pending = 0;
          scan_char(CH_CR);
        end
        push_verdict(ST_NO_CRLF, MC_GET);
        phase = PH_DONE;
      end
      return 1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [55:0] d);
      result_t got;
      result_t want;
      got = d[53:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected verdict, expected none actual %h", $time, d);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("method_code", want.method_code, got.method_code);
      compare_field("uri_offset", want.uri_offset, got.uri_offset);
      compare_field("uri_length", want.uri_length, got.uri_length);
      compare_field("line_length", want.line_length, got.line_length);
      compare_field("pad bits", 0, d[55:54]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  line_scoreboard board;
  logic [7:0]     msg[$];
  string          method_text[4] = '{"GET", "POST", "DELETE", "HEAD"};
  int unsigned    cycles = 0;
  int unsigned    burst_left = 0;
  int unsigned    sent_words = 0;

  http_request_line_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern changes with bits 10:9 of the cycle counter
  always @(posedge clk) begin
    case (cycles[10:9])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 1) == 1);
      2'd2: out_tready <= (cycles[2:0] >= 3'd3);
      default: out_tready <= (cycles[5:0] < 6'd16);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_verdict(out_tdata);
  end

  function automatic logic [7:0] token_char();
    return 8'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 3))
      0: return CH_LF;
      1: return CH_VT;
      2: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
  endtask

  task automatic add_crlf();
    msg.push_back(CH_CR);
    msg.push_back(CH_LF);
  endtask

  task automatic send_byte(logic [7:0] b, bit first, bit last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    void'(board.note_byte(b, first, last));
    sent_words++;
  endtask

  task automatic send_message(bit with_end);
    for (int i = 0; i < msg.size(); i++)
      send_byte(msg[i], i == 0, with_end && i == msg.size() - 1);
  endtask

  task automatic build_line(output bit with_end);
    flaw_t       flaw;
    int unsigned k;
    int unsigned at;
    int unsigned ntok;
    int unsigned keep;
    logic [7:0]  sep1;
    logic [7:0]  sep2;
    msg.delete();
    flaw = ($urandom_range(0, 9) < 4) ? F_NONE : flaw_t'($urandom_range(1, int'(F_NOISE)));
    with_end = ($urandom_range(0, 2) == 0);
    if (flaw == F_EMPTY) begin
      add_crlf();
    end else if (flaw == F_NOISE) begin
      repeat ($urandom_range(1, 30)) msg.push_back(8'($urandom_range(0, 255)));
    end else begin
      sep1 = CH_SP;
      sep2 = CH_SP;
      ntok = 3;
      if (flaw == F_ALT_SEP) begin
        sep1 = pick_sep();
        sep2 = pick_sep();
      end
      if (flaw == F_TAB) begin
        if ($urandom_range(0, 1)) sep1 = CH_TAB;
        else sep2 = CH_TAB;
      end
      if (flaw == F_FEW) ntok = $urandom_range(1, 2);
      if (flaw == F_LEAD) msg.push_back(CH_SP);
      k = $urandom_range(0, 3);
      at = msg.size();
      if (flaw == F_UNKNOWN) repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(CH_UA, CH_UZ)));
      else add_text(method_text[k]);
      if (flaw == F_LOWER) begin
        at = at + $urandom_range(0, method_text[k].len() - 1);
        msg[at] = msg[at] + 8'h20;
      end
      if (ntok >= 2) begin
        msg.push_back(sep1);
        if (flaw == F_DBL && $urandom_range(0, 1)) msg.push_back(CH_SP);
        at = msg.size();
        msg.push_back(CH_SLASH);
        repeat ($urandom_range(0, 12)) msg.push_back(token_char());
        // non-slash first char for a bad uri
        if (flaw == F_BAD_URI) msg[at] = 8'($urandom_range(8'h61, 8'h7A));
      end
      if (ntok == 3) begin
        msg.push_back(sep2);
        if (flaw == F_DBL) msg.push_back(CH_SP);
        at = msg.size();
        add_text("HTTP/1.1");
        if (flaw == F_BAD_VER) begin
          if ($urandom_range(0, 2) == 0) msg.push_back(token_char());
          else msg[at + $urandom_range(0, VERSION_LEN - 1)] = token_char();
        end
      end
      if (flaw == F_MANY) begin
        msg.push_back(CH_SP);
        repeat ($urandom_range(1, 5)) msg.push_back(token_char());
      end
      if (flaw == F_TRAIL) msg.push_back(CH_SP);
      if (flaw == F_NO_CRLF) begin
        if ($urandom_range(0, 1)) msg.push_back(CH_CR);
        with_end = 1;
      end else begin
        add_crlf();
        repeat ($urandom_range(0, 6)) msg.push_back(8'($urandom_range(0, 255)));
      end
    end
    // cut short, so the next message restarts mid-line
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, msg.size());
      while (msg.size() > keep) void'(msg.pop_back());
      with_end = 0;
    end
  endtask

  initial begin
    bit          with_end;
    int unsigned drain;
    board = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle words without a first flag are dropped
    send_byte(8'h00, 0, 0);
    send_byte(8'hFF, 0, 0);
    msg.delete();
    add_crlf();
    send_message(0);
    msg.delete();
    add_text("GE");
    send_message(0);
    msg.delete();
    msg.push_back(CH_CR);
    send_message(1);
    msg.delete();
    add_text("GET / HTTP/1.1");
    add_crlf();
    send_message(1);
    send_byte(8'hA5, 0, 1);

    while (sent_words < TOTAL_WORDS) begin
      build_line(with_end);
      send_message(with_end);
    end
    in_tvalid <= 1'b0;

    drain = 0;
    while (board.pending.size() != 0 && drain < 4000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (board.pending.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, board.pending.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
